// File: rtl/complex_arithmetic_unit_defines.svh
// Assertion macros used by the checker file of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CAU_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cau_pkg.sv
// Package of the complex arithmetic unit: widths, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W   = 2 * DATA_WIDTH;        // one full product
  localparam int SUM_W    = 2 * DATA_WIDTH + 1;    // sum of two products
  localparam int QUO_W    = DATA_WIDTH + 1;        // quotient bits kept
  localparam int NUM_W    = PROD_W + FRAC_BITS;    // scaled numerator magnitude
  localparam int LANE_LAT = QUO_W + 1;             // divider lane register stages

  localparam logic [DATA_WIDTH-1:0] RES_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] RES_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  // Result of one divider lane.
  typedef struct packed {
    logic [QUO_W-1:0] q;
    logic             ovf;
  } div_res_t;

  // Sideband that travels next to the divider lanes.
  typedef struct packed {
    logic                  is_div;
    logic                  zero;
    logic                  neg_re;
    logic                  neg_im;
    logic [DATA_WIDTH-1:0] re;
    logic [DATA_WIDTH-1:0] im;
    logic                  sat;
  } tag_t;

  // One finished result.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] re;
    logic [DATA_WIDTH-1:0] im;
    status_t               status;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply and divide on Q16.16 pairs.
// One transaction per cycle enters while in_stall is low, and one result per transaction
// leaves, in order. The divider sets the depth: two lanes, one per result part, each a
// chain of DATA_WIDTH + 1 restoring compare-subtract stages after a range check, behind
// three stages of products and wide sums. Every operation takes the same path so results
// stay in order. Two output registers hold finished results; in_stall rises only when
// both are full and the whole pipeline then holds. Products round toward minus infinity,
// quotients toward zero; out-of-range parts saturate with status 2, and a zero divisor
// gives a zero result with status 1.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic [1:0]                   out_status
);

  function automatic logic [DATA_WIDTH:0] sat_fix(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_WIDTH:0] top;
    logic                      big;
    logic [DATA_WIDTH-1:0]     val;
    top = v[SUM_W-1:DATA_WIDTH-1];
    big = !((&top) || (~|top));
    val = big ? (v[SUM_W-1] ? RES_MIN : RES_MAX) : v[DATA_WIDTH-1:0];
    return {big, val};
  endfunction

  function automatic logic [DATA_WIDTH:0] div_fix(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic                  big;
    logic [DATA_WIDTH-1:0] val;
    big = ovf | q[DATA_WIDTH] |
          (neg ? (q[DATA_WIDTH-1] & (|q[DATA_WIDTH-2:0])) : q[DATA_WIDTH-1]);
    if (big) begin
      val = neg ? RES_MIN : RES_MAX;
    end else begin
      val = neg ? DATA_WIDTH'(~q[DATA_WIDTH-1:0] + 1'b1) : q[DATA_WIDTH-1:0];
    end
    return {big, val};
  endfunction

  logic en;
  logic [1:0] count_r, count_nxt;
  logic push, pop;

  // Stage 1: products and short sums.
  logic                         s1_v_r;
  cmd_t                         s1_cmd_r;
  logic                         s1_zero_r;
  logic signed [PROD_W-1:0]     s1_rr_r, s1_ii_r, s1_ri_r, s1_ir_r, s1_bb_r, s1_jj_r;
  logic signed [DATA_WIDTH:0]   s1_as_re_r, s1_as_im_r;

  // Stage 2: wide sums and divisor.
  logic                         s2_v_r;
  cmd_t                         s2_cmd_r;
  logic                         s2_zero_r;
  logic signed [SUM_W-1:0]      s2_re_r, s2_im_r, s2_re_nxt, s2_im_nxt;
  logic [PROD_W-1:0]            s2_den_r;

  // Stage 3: direct results, or magnitudes for the divider.
  logic                         s3_v_r;
  tag_t                         s3_tag_r, s3_tag_nxt;
  logic [PROD_W-1:0]            s3_mag_re_r, s3_mag_im_r, s3_den_r;
  logic signed [SUM_W-1:0]      val_re, val_im;
  logic [SUM_W-1:0]             abs_re, abs_im;
  logic [DATA_WIDTH:0]          fix_re, fix_im;

  logic                         dv_r  [0:LANE_LAT-1];
  tag_t                         tag_r [0:LANE_LAT-1];
  div_res_t                     q_re, q_im;

  res_t                         fin;
  logic [DATA_WIDTH:0]          dfix_re, dfix_im;
  res_t                         main_r, skid_r;

  // Hold everything while both output registers are full.
  assign en       = (count_r != 2'd2);
  assign in_stall = !en;
  assign pop      = out_valid && !out_stall;
  assign push     = en && dv_r[LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r   <= cmd_t'(in_cmd);
      s1_zero_r  <= (in_b_re == '0) && (in_b_im == '0);
      s1_rr_r    <= in_a_re * in_b_re;
      s1_ii_r    <= in_a_im * in_b_im;
      s1_ri_r    <= in_a_re * in_b_im;
      s1_ir_r    <= in_a_im * in_b_re;
      s1_bb_r    <= in_b_re * in_b_re;
      s1_jj_r    <= in_b_im * in_b_im;
      s1_as_re_r <= (cmd_t'(in_cmd) == CMD_SUB) ? (in_a_re - in_b_re) : (in_a_re + in_b_re);
      s1_as_im_r <= (cmd_t'(in_cmd) == CMD_SUB) ? (in_a_im - in_b_im) : (in_a_im + in_b_im);
    end
  end

  always_comb begin
    case (s1_cmd_r)
      CMD_MUL: begin
        s2_re_nxt = s1_rr_r - s1_ii_r;
        s2_im_nxt = s1_ri_r + s1_ir_r;
      end
      CMD_DIV: begin
        s2_re_nxt = s1_rr_r + s1_ii_r;
        s2_im_nxt = s1_ir_r - s1_ri_r;
      end
      default: begin
        s2_re_nxt = SUM_W'(s1_as_re_r);
        s2_im_nxt = SUM_W'(s1_as_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_zero_r <= s1_zero_r;
      s2_re_r   <= s2_re_nxt;
      s2_im_r   <= s2_im_nxt;
      s2_den_r  <= $unsigned(s1_bb_r) + $unsigned(s1_jj_r);
    end
  end

  always_comb begin
    val_re = (s2_cmd_r == CMD_MUL) ? (s2_re_r >>> FRAC_BITS) : s2_re_r;
    val_im = (s2_cmd_r == CMD_MUL) ? (s2_im_r >>> FRAC_BITS) : s2_im_r;
    fix_re = sat_fix(val_re);
    fix_im = sat_fix(val_im);
    abs_re = s2_re_r[SUM_W-1] ? SUM_W'(-s2_re_r) : SUM_W'(s2_re_r);
    abs_im = s2_im_r[SUM_W-1] ? SUM_W'(-s2_im_r) : SUM_W'(s2_im_r);
    s3_tag_nxt.is_div = (s2_cmd_r == CMD_DIV);
    s3_tag_nxt.zero   = s2_zero_r;
    s3_tag_nxt.neg_re = s2_re_r[SUM_W-1];
    s3_tag_nxt.neg_im = s2_im_r[SUM_W-1];
    s3_tag_nxt.re     = fix_re[DATA_WIDTH-1:0];
    s3_tag_nxt.im     = fix_im[DATA_WIDTH-1:0];
    s3_tag_nxt.sat    = fix_re[DATA_WIDTH] | fix_im[DATA_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag_r    <= s3_tag_nxt;
      s3_mag_re_r <= abs_re[PROD_W-1:0];
      s3_mag_im_r <= abs_im[PROD_W-1:0];
      s3_den_r    <= s2_den_r;
    end
  end

  cau_div_lane u_div_re (
    .clk (clk),
    .en  (en),
    .mag (s3_mag_re_r),
    .den (s3_den_r),
    .res (q_re)
  );

  cau_div_lane u_div_im (
    .clk (clk),
    .en  (en),
    .mag (s3_mag_im_r),
    .den (s3_den_r),
    .res (q_im)
  );

  // Sideband and valid bits ride alongside the divider lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (en) begin
      dv_r[0] <= s3_v_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= s3_tag_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  always_comb begin
    dfix_re = div_fix(q_re.q, q_re.ovf, tag_r[LANE_LAT-1].neg_re);
    dfix_im = div_fix(q_im.q, q_im.ovf, tag_r[LANE_LAT-1].neg_im);
    if (!tag_r[LANE_LAT-1].is_div) begin
      fin.re     = tag_r[LANE_LAT-1].re;
      fin.im     = tag_r[LANE_LAT-1].im;
      fin.status = tag_r[LANE_LAT-1].sat ? STAT_SAT : STAT_OK;
    end else if (tag_r[LANE_LAT-1].zero) begin
      fin.re     = '0;
      fin.im     = '0;
      fin.status = STAT_DIV0;
    end else begin
      fin.re     = dfix_re[DATA_WIDTH-1:0];
      fin.im     = dfix_im[DATA_WIDTH-1:0];
      fin.status = (dfix_re[DATA_WIDTH] | dfix_im[DATA_WIDTH]) ? STAT_SAT : STAT_OK;
    end
  end

  // Two-entry output buffer: main_r drives the ports, skid_r catches one more.
  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (count_r == 2'd2)) begin
      main_r <= skid_r;
    end else if (push && ((count_r == 2'd0) || pop)) begin
      main_r <= fin;
    end
    if (push && (count_r == 2'd1) && !pop) begin
      skid_r <= fin;
    end
  end

  assign out_valid  = (count_r != 2'd0);
  assign out_res_re = main_r.re;
  assign out_res_im = main_r.im;
  assign out_status = main_r.status;

endmodule

`default_nettype wire

// File: rtl/cau_div_lane.sv
// Pipelined restoring divider lane: one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module cau_div_lane import cau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [PROD_W-1:0] mag,
  input  logic [PROD_W-1:0] den,
  output div_res_t          res
);

  logic [PROD_W-1:0] rem_r [0:QUO_W-1];
  logic [PROD_W-1:0] den_r [0:QUO_W-1];
  logic [QUO_W-1:0]  low_r [0:QUO_W-1];
  logic [QUO_W-1:0]  q_r   [0:QUO_W];
  logic              ovf_r [0:QUO_W];

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] hi;
  logic             ovf_nxt;

  // The quotient can only fit in QUO_W bits when num >> QUO_W stays below den.
  always_comb begin
    num     = NUM_W'(mag) << FRAC_BITS;
    hi      = num >> QUO_W;
    ovf_nxt = (hi >= NUM_W'(den));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi[PROD_W-1:0];
      den_r[0] <= den;
      low_r[0] <= num[QUO_W-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_nxt;
    end
  end

  for (genvar i = 1; i <= QUO_W; i++) begin : g_bit
    logic [PROD_W:0] trial;
    logic [PROD_W:0] diff;
    logic            take;

    // The remainder stays below the divisor, so the borrow bit decides the step.
    always_comb begin
      trial = {rem_r[i-1], low_r[i-1][QUO_W-1]};
      diff  = trial - {1'b0, den_r[i-1]};
      take  = !diff[PROD_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i]   <= {q_r[i-1][QUO_W-2:0], take};
        ovf_r[i] <= ovf_r[i-1];
      end
    end

    if (i < QUO_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= take ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
          den_r[i] <= den_r[i-1];
          low_r[i] <= low_r[i-1] << 1;
        end
      end
    end
  end

  assign res.q   = q_r[QUO_W];
  assign res.ovf = ovf_r[QUO_W];

endmodule

`default_nettype wire

// File: rtl/cau_checker.sv
// Port-level checker of the complex arithmetic unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_defines.svh"

module cau_checker import cau_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] out_res_re,
  input logic [DATA_WIDTH-1:0] out_res_im,
  input logic [1:0]            out_status
);

  // A zero divisor always comes out as a zero result.
  `CAU_ASSERT(a_div0_zero, out_valid && (out_status == STAT_DIV0),
              (out_res_re == '0) && (out_res_im == '0),
              "divide by zero result is not zero")

  // A saturated transaction must carry at least one clamped part.
  `CAU_ASSERT(a_sat_clamped, out_valid && (out_status == STAT_SAT),
              (out_res_re == RES_MAX) || (out_res_re == RES_MIN) ||
              (out_res_im == RES_MAX) || (out_res_im == RES_MIN),
              "saturated status without a clamped part")

  // The input side only backs up once a result is waiting.
  `CAU_ASSERT(a_stall_needs_out, !out_valid, !in_stall, "input stalled with no result pending")

  // A stalled result holds.
  `CAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_res_re) && $stable(out_res_im) &&
                   $stable(out_status),
                   "stalled result changed")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

`default_nettype wire
